[hdl/trd_pkg.sv]
package trd_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int COORD_W  = 12;
  localparam int DEPTH_W  = 16;
  localparam int COLOUR_W = 32;
  localparam int SCREEN_W = 9;
  localparam int PIX_W    = 8;
  localparam int EDGE_W   = 28;
  localparam int NUM_W    = 46;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] K_LOADED   = 3'd0;
  localparam logic [2:0] K_REJECTED = 3'd1;
  localparam logic [2:0] K_VISITED  = 3'd2;
  localparam logic [2:0] K_WRITTEN  = 3'd3;
  localparam logic [2:0] K_IDLE     = 3'd4;
  localparam logic [2:0] K_CLEARED  = 3'd5;

  localparam logic [1:0] CMD_RESULT = 2'd0;
  localparam logic [1:0] CMD_STEP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic signed [DEPTH_W-1:0] LOWEST_DEPTH  = 16'sh8000;
  localparam logic signed [DEPTH_W-1:0] HIGHEST_DEPTH = 16'sh7fff;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0]       cmd;
    logic [2:0]       kind;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [DEPTH_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [DEPTH_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [DEPTH_W-1:0] cz;
    logic signed [EDGE_W-1:0]  area;
    logic [COLOUR_W-1:0]       colour;
  } vertex_set_t;

  function automatic logic signed [EDGE_W-1:0] edge_fn(
    input logic signed [COORD_W-1:0] x0,
    input logic signed [COORD_W-1:0] y0,
    input logic signed [COORD_W-1:0] x1,
    input logic signed [COORD_W-1:0] y1,
    input logic signed [COORD_W:0]   px,
    input logic signed [COORD_W:0]   py
  );
    logic signed [COORD_W+1:0] dx;
    logic signed [COORD_W+1:0] dy;
    logic signed [COORD_W+1:0] ex;
    logic signed [COORD_W+1:0] ey;
    logic signed [EDGE_W-1:0]  p1;
    logic signed [EDGE_W-1:0]  p2;
    dx = x1 - x0;
    dy = y1 - y0;
    ex = px - x0;
    ey = py - y0;
    p1 = dx * ey;
    p2 = dy * ex;
    return p1 - p2;
  endfunction

  function automatic logic [SCREEN_W-1:0] eff_dim(input logic [SCREEN_W-1:0] v,
                                                 input logic [SCREEN_W-1:0] maxv);
    if (v == '0) return SCREEN_W'(1);
    if (v > maxv) return maxv;
    return v;
  endfunction

endpackage

[hdl/trd_queue.sv]
module trd_queue
  import trd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t                 slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_PTR_W:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

[hdl/trd_front.sv]
module trd_front
  import trd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 operation,
  input  logic signed [COORD_W-1:0]  ax,
  input  logic signed [COORD_W-1:0]  ay,
  input  logic signed [DEPTH_W-1:0]  az,
  input  logic signed [COORD_W-1:0]  bx,
  input  logic signed [COORD_W-1:0]  by_coord,
  input  logic signed [DEPTH_W-1:0]  bz,
  input  logic signed [COORD_W-1:0]  cx,
  input  logic signed [COORD_W-1:0]  cy,
  input  logic signed [DEPTH_W-1:0]  cz,
  input  logic [COLOUR_W-1:0]        fill_colour,
  input  logic [SCREEN_W-1:0]        w_eff,
  input  logic [SCREEN_W-1:0]        h_eff,
  input  logic                       back_busy,
  input  logic                       q_full,
  output logic                       q_push,
  output cmd_t                       q_data,
  output vertex_set_t                vset
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HOLD = 2'd1;
  localparam logic [1:0] F_LOAD = 2'd2;

  logic [1:0]       state;
  logic [1:0]       op_h;
  vertex_set_t      item;
  logic             active;
  logic [PIX_W-1:0] box_lx;
  logic [PIX_W-1:0] box_hx;
  logic [PIX_W-1:0] box_ly;
  logic [PIX_W-1:0] box_hy;
  logic [PIX_W-1:0] cur_x;
  logic [PIX_W-1:0] cur_y;

  logic signed [EDGE_W-1:0]  area;
  logic signed [COORD_W:0]   lx;
  logic signed [COORD_W:0]   hx;
  logic signed [COORD_W:0]   ly;
  logic signed [COORD_W:0]   hy;
  logic signed [COORD_W:0]   wm1;
  logic signed [COORD_W:0]   hm1;
  logic                      reject;
  logic                      y_end;
  logic                      x_end;

  function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b,
                                                     input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b,
                                                     input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  assign full = (state != F_IDLE);

  // Box setup works from the latched vertices, so the back end has gone idle by then.
  always_comb begin
    area = edge_fn(vset.ax, vset.ay, vset.bx, vset.by, vset.cx, vset.cy);
    wm1  = signed'({4'b0, w_eff - 1'b1});
    hm1  = signed'({4'b0, h_eff - 1'b1});
    lx   = min3(vset.ax, vset.bx, vset.cx);
    hx   = max3(vset.ax, vset.bx, vset.cx);
    ly   = min3(vset.ay, vset.by, vset.cy);
    hy   = max3(vset.ay, vset.by, vset.cy);
    if (lx < 0) lx = '0;
    if (ly < 0) ly = '0;
    if (hx > wm1) hx = wm1;
    if (hy > hm1) hy = hm1;
    reject = (area == '0) || (lx > hx) || (ly > hy);
    y_end  = !(cur_y < box_hy);
    x_end  = !(cur_x < box_hx);
  end

  always_comb begin
    q_push = 1'b0;
    q_data = '0;
    case (state)
      F_HOLD: begin
        case (op_h)
          OP_LOAD: q_push = 1'b0;
          OP_STEP: begin
            q_push = 1'b1;
            if (active) begin
              q_data.cmd  = CMD_STEP;
              q_data.px   = cur_x;
              q_data.py   = cur_y;
              q_data.last = y_end && x_end;
            end else begin
              q_data.cmd  = CMD_RESULT;
              q_data.kind = K_IDLE;
            end
          end
          OP_CLEAR: begin
            q_push     = 1'b1;
            q_data.cmd = CMD_CLEAR;
          end
          default: begin
            q_push      = 1'b1;
            q_data.cmd  = CMD_RESULT;
            q_data.kind = K_IDLE;
          end
        endcase
      end
      F_LOAD: begin
        q_push      = 1'b1;
        q_data.cmd  = CMD_RESULT;
        q_data.kind = reject ? K_REJECTED : K_LOADED;
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      active <= 1'b0;
      box_lx <= '0;
      box_hx <= '0;
      box_ly <= '0;
      box_hy <= '0;
      cur_x  <= '0;
      cur_y  <= '0;
      vset   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) state <= F_HOLD;
        end
        F_HOLD: begin
          if (op_h == OP_LOAD) begin
            // Vertices are shared with the back end; replace them only once it drains.
            if (!back_busy) begin
              vset  <= item;
              state <= F_LOAD;
            end
          end else if (!q_full) begin
            state <= F_IDLE;
            if (op_h == OP_STEP && active) begin
              if (!y_end) begin
                cur_y <= cur_y + 1'b1;
              end else begin
                cur_y <= box_ly;
                if (!x_end) cur_x <= cur_x + 1'b1;
                else active <= 1'b0;
              end
            end
          end
        end
        F_LOAD: begin
          if (!q_full) begin
            state     <= F_IDLE;
            vset.area <= area;
            active    <= !reject;
            if (!reject) begin
              box_lx <= lx[PIX_W-1:0];
              box_hx <= hx[PIX_W-1:0];
              box_ly <= ly[PIX_W-1:0];
              box_hy <= hy[PIX_W-1:0];
              cur_x  <= lx[PIX_W-1:0];
              cur_y  <= ly[PIX_W-1:0];
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      op_h        <= operation;
      item.ax     <= ax;
      item.ay     <= ay;
      item.az     <= az;
      item.bx     <= bx;
      item.by     <= by_coord;
      item.bz     <= bz;
      item.cx     <= cx;
      item.cy     <= cy;
      item.cz     <= cz;
      item.area   <= '0;
      item.colour <= fill_colour;
    end
  end

endmodule

[hdl/trd_back.sv]
module trd_back
  import trd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  cmd_t                       q_head,
  output logic                       q_pop,
  input  vertex_set_t                vset,
  input  logic [SCREEN_W-1:0]        w_eff,
  input  logic [SCREEN_W-1:0]        h_eff,
  output logic                       busy,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 kind,
  output logic [PIX_W-1:0]           pixel_x,
  output logic [PIX_W-1:0]           pixel_y,
  output logic [COLOUR_W-1:0]        pixel_colour,
  output logic signed [DEPTH_W-1:0]  pixel_depth,
  output logic                       last
);

  localparam logic [3:0] B_SWEEP = 4'd0;
  localparam logic [3:0] B_IDLE  = 4'd1;
  localparam logic [3:0] B_EDGE  = 4'd2;
  localparam logic [3:0] B_TEST  = 4'd3;
  localparam logic [3:0] B_MUL   = 4'd4;
  localparam logic [3:0] B_DSET  = 4'd5;
  localparam logic [3:0] B_DIV   = 4'd6;
  localparam logic [3:0] B_FIX   = 4'd7;
  localparam logic [3:0] B_CMP   = 4'd8;
  localparam logic [3:0] B_DONE  = 4'd9;

  localparam int DCNT_W = $clog2(NUM_W);

  logic signed [DEPTH_W-1:0] depth_mem [STORE_DEPTH];

  logic [3:0]                state;
  cmd_t                      cmd_r;
  logic [1:0]                cnt;
  logic signed [EDGE_W-1:0]  e_ab;
  logic signed [EDGE_W-1:0]  e_bc;
  logic signed [EDGE_W-1:0]  e_ca;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          dvd;
  logic [EDGE_W-1:0]         dmag;
  logic [EDGE_W-1:0]         rem;
  logic [NUM_W-1:0]          quo;
  logic [DCNT_W-1:0]         dcnt;
  logic                      neg;
  logic signed [DEPTH_W-1:0] z;
  logic [ADDR_W-1:0]         addr;
  logic signed [DEPTH_W-1:0] rd_data;
  logic [ADDR_W-1:0]         sweep_addr;
  logic                      report;

  logic [2:0]                res_kind;
  logic [COLOUR_W-1:0]       res_colour;
  logic signed [DEPTH_W-1:0] res_depth;

  logic                      out_valid;
  logic                      out_load;

  logic signed [COORD_W-1:0] ex0, ey0, ex1, ey1;
  logic signed [COORD_W:0]   ppx, ppy;
  logic signed [EDGE_W-1:0]  edge_val;
  logic signed [EDGE_W-1:0]  m_e;
  logic signed [DEPTH_W-1:0] m_z;
  logic signed [NUM_W-1:0]   prod;
  logic                      covered;
  logic                      on_screen;
  logic [EDGE_W:0]           trial;
  logic                      ge;
  logic signed [DEPTH_W-1:0] z_fix;
  logic [ADDR_W+SCREEN_W-1:0] idx_full;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic signed [DEPTH_W-1:0] mem_wdata;

  assign empty    = !out_valid;
  assign busy     = (state != B_IDLE) || !q_empty;
  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign out_load = (state == B_DONE) && (!out_valid || pop);

  always_comb begin
    ppx = signed'({5'b0, cmd_r.px});
    ppy = signed'({5'b0, cmd_r.py});
    case (cnt)
      2'd0: begin
        ex0 = vset.ax; ey0 = vset.ay; ex1 = vset.bx; ey1 = vset.by;
        m_e = e_bc;    m_z = vset.az;
      end
      2'd1: begin
        ex0 = vset.bx; ey0 = vset.by; ex1 = vset.cx; ey1 = vset.cy;
        m_e = e_ca;    m_z = vset.bz;
      end
      default: begin
        ex0 = vset.cx; ey0 = vset.cy; ex1 = vset.ax; ey1 = vset.ay;
        m_e = e_ab;    m_z = vset.cz;
      end
    endcase
    edge_val = edge_fn(ex0, ey0, ex1, ey1, ppx, ppy);
    prod     = m_e * m_z;

    covered = (vset.area > 0 && e_ab >= 0 && e_bc >= 0 && e_ca >= 0) ||
              (vset.area < 0 && e_ab <= 0 && e_bc <= 0 && e_ca <= 0);
    on_screen = ({1'b0, cmd_r.px} < w_eff) && ({1'b0, cmd_r.py} < h_eff);

    trial = {rem, dvd[NUM_W-1]};
    ge    = (trial >= {1'b0, dmag});

    if (neg) begin
      if (quo > NUM_W'(32768)) z_fix = LOWEST_DEPTH;
      else z_fix = -signed'(quo[DEPTH_W-1:0]);
    end else begin
      if (quo > NUM_W'(32767)) z_fix = HIGHEST_DEPTH;
      else z_fix = signed'(quo[DEPTH_W-1:0]);
    end

    idx_full = (ADDR_W+SCREEN_W)'(cmd_r.px) + (ADDR_W+SCREEN_W)'(cmd_r.py) * w_eff;

    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = z;
    if (state == B_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = LOWEST_DEPTH;
    end else if (state == B_CMP && z > rd_data) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) depth_mem[mem_waddr] <= mem_wdata;
    if (state == B_FIX) rd_data <= depth_mem[idx_full[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_SWEEP;
      sweep_addr <= '0;
      report     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;

      case (state)
        B_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == ADDR_W'(STORE_DEPTH - 1)) state <= report ? B_DONE : B_IDLE;
        end
        B_IDLE: begin
          if (!q_empty) begin
            case (q_head.cmd)
              CMD_STEP:  state <= B_EDGE;
              CMD_CLEAR: begin
                state      <= B_SWEEP;
                sweep_addr <= '0;
                report     <= 1'b1;
              end
              default:   state <= B_DONE;
            endcase
          end
        end
        B_EDGE: if (cnt == 2'd2) state <= B_TEST;
        B_TEST: state <= (covered && on_screen) ? B_MUL : B_DONE;
        B_MUL:  if (cnt == 2'd2) state <= B_DSET;
        B_DSET: state <= B_DIV;
        B_DIV:  if (dcnt == DCNT_W'(NUM_W - 1)) state <= B_FIX;
        B_FIX:  state <= B_CMP;
        B_CMP:  state <= B_DONE;
        B_DONE: if (out_load) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cmd_r      <= q_head;
        cnt        <= '0;
        res_colour <= '0;
        res_depth  <= '0;
        case (q_head.cmd)
          CMD_STEP:  res_kind <= K_VISITED;
          CMD_CLEAR: res_kind <= K_CLEARED;
          default:   res_kind <= q_head.kind;
        endcase
      end
      B_EDGE: begin
        cnt <= cnt + 1'b1;
        case (cnt)
          2'd0:    e_ab <= edge_val;
          2'd1:    e_bc <= edge_val;
          default: e_ca <= edge_val;
        endcase
      end
      B_TEST: cnt <= '0;
      B_MUL: begin
        cnt <= cnt + 1'b1;
        num <= ((cnt == 2'd0) ? '0 : num) + prod;
      end
      B_DSET: begin
        dvd  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dmag <= vset.area[EDGE_W-1] ? EDGE_W'(-vset.area) : EDGE_W'(vset.area);
        neg  <= num[NUM_W-1] ^ vset.area[EDGE_W-1];
        rem  <= '0;
        quo  <= '0;
        dcnt <= '0;
      end
      B_DIV: begin
        rem  <= ge ? EDGE_W'(trial - {1'b0, dmag}) : trial[EDGE_W-1:0];
        dvd  <= {dvd[NUM_W-2:0], 1'b0};
        quo  <= {quo[NUM_W-2:0], ge};
        dcnt <= dcnt + 1'b1;
      end
      B_FIX: begin
        z         <= z_fix;
        res_depth <= z_fix;
        addr      <= idx_full[ADDR_W-1:0];
      end
      B_CMP: begin
        if (z > rd_data) begin
          res_kind   <= K_WRITTEN;
          res_colour <= vset.colour;
        end
      end
      default: cnt <= cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind         <= res_kind;
      pixel_colour <= res_colour;
      pixel_depth  <= res_depth;
      if (cmd_r.cmd == CMD_STEP) begin
        pixel_x <= cmd_r.px;
        pixel_y <= cmd_r.py;
        last    <= cmd_r.last;
      end else begin
        pixel_x <= '0;
        pixel_y <= '0;
        last    <= 1'b0;
      end
    end
  end

  // A finished result never overwrites one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || pop))
    else $error("result register overwritten");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != B_IDLE))
    else $error("command taken without leaving idle");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |=> (state == B_DIV || state == B_FIX))
    else $error("divider left early");

  a_sweep_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == B_SWEEP) |-> !q_pop)
    else $error("command taken during clearing sweep");

endmodule

[hdl/triangle_raster_depth_test.sv]
// Triangle rasterizer with a depth store. Each item gives exactly one result, in order.
// A step over a covered on-screen position spends most of its time in the one-bit-per-cycle
// depth divider, which yields a 46-bit quotient; an uncovered position skips the divider.
// A clear rewrites the whole 65536-entry depth store one entry per cycle, and the same
// clearing pass runs after reset; items are taken during it, but their results wait
// until it ends. A load waits until all earlier steps have finished, since they share
// the vertex registers.
module triangle_raster_depth_test
  import trd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 operation,
  input  logic signed [COORD_W-1:0]  ax,
  input  logic signed [COORD_W-1:0]  ay,
  input  logic signed [DEPTH_W-1:0]  az,
  input  logic signed [COORD_W-1:0]  bx,
  input  logic signed [COORD_W-1:0]  by_coord,
  input  logic signed [DEPTH_W-1:0]  bz,
  input  logic signed [COORD_W-1:0]  cx,
  input  logic signed [COORD_W-1:0]  cy,
  input  logic signed [DEPTH_W-1:0]  cz,
  input  logic [COLOUR_W-1:0]        fill_colour,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 kind,
  output logic [PIX_W-1:0]           pixel_x,
  output logic [PIX_W-1:0]           pixel_y,
  output logic [COLOUR_W-1:0]        pixel_colour,
  output logic signed [DEPTH_W-1:0]  pixel_depth,
  output logic                       last,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [SCREEN_W-1:0]        cfg_data
);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;
  logic [SCREEN_W-1:0] w_eff;
  logic [SCREEN_W-1:0] h_eff;
  logic                back_busy;
  logic                q_full;
  logic                q_push;
  cmd_t                q_data;
  logic                q_pop;
  cmd_t                q_head;
  logic                q_empty;
  vertex_set_t         vset;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_W'(MAX_WIDTH);
      screen_height <= SCREEN_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  screen_width  <= cfg_data;
        REG_HEIGHT: screen_height <= cfg_data;
        default:    screen_width  <= screen_width;
      endcase
    end
  end

  assign w_eff = eff_dim(screen_width, SCREEN_W'(MAX_WIDTH));
  assign h_eff = eff_dim(screen_height, SCREEN_W'(MAX_HEIGHT));

  trd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .operation   (operation),
    .ax          (ax),
    .ay          (ay),
    .az          (az),
    .bx          (bx),
    .by_coord    (by_coord),
    .bz          (bz),
    .cx          (cx),
    .cy          (cy),
    .cz          (cz),
    .fill_colour (fill_colour),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .back_busy   (back_busy),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data),
    .vset        (vset)
  );

  trd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  trd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .vset         (vset),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .busy         (back_busy),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_colour (pixel_colour),
    .pixel_depth  (pixel_depth),
    .last         (last)
  );

endmodule
